[hdl/psnm_pkg.sv]
// shared constants, types and constant tables of the sine note mixer
`timescale 1ns / 1ps
package psnm_pkg;

  localparam int VOICES          = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_RATE     = 44100;

  localparam int SLOT_AW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int QTR_BITS  = SINE_TABLE_BITS - 2;
  localparam int QTR_SIZE  = 1 << QTR_BITS;
  localparam int ACC_W     = 17 + $clog2(VOICES + 1);
  localparam int MAG3_W    = ACC_W + 1;
  localparam int WAIT_LEN  = 7;
  localparam int STEP_W    = $clog2(VOICES + WAIT_LEN);
  localparam int VOICE_W   = 32 + 32 + 7;

  // request kinds on in_req_type
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [15:0] FULL_SCALE = 16'd32767;
  // 3 * |acc| at or above this saturates
  localparam logic [18:0] MAG_LIM    = 19'd327670;
  // floor(x / 10) = (x * RECIP_10) >> 23 for x below 2^19
  localparam logic [19:0] RECIP_10   = 20'd838861;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] PICO        = 64'd1000000000000;
  localparam logic [63:0] STEP_DEN    = 64'(SAMPLE_RATE) * PICO;

  localparam logic [63:0] OCTAVE0_PHZ [12] = '{
    64'd8175798915644,  64'd8661957218027,  64'd9177023997419,  64'd9722718241315,
    64'd10300861153527, 64'd10913382232281, 64'd11562325709739, 64'd12249857374430,
    64'd12978271799373, 64'd13750000000000, 64'd14567617547440, 64'd15433853164254
  };

  localparam logic [63:0] TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef logic [31:0] key_inc_tab_t [128];
  typedef logic [15:0] sine_qtr_tab_t [QTR_SIZE + 1];

  // controller to datapath commands
  typedef struct packed {
    logic               load;
    logic               acc_clr;
    logic               issue;
    logic [SLOT_AW-1:0] slot;
    logic               emit;
  } psnm_cmd_t;

  // phase increment per sample as a 32-bit cycle fraction, rounded half up
  function automatic logic [31:0] step_for_key(input int unsigned key);
    logic [63:0] f;
    logic [63:0] r;
    logic [31:0] q;
    f = OCTAVE0_PHZ[key % 12] << (key / 12);
    r = f;
    for (int i = 0; i < 8; i++) begin
      if (r >= STEP_DEN) r = r - STEP_DEN;
    end
    q = '0;
    for (int i = 0; i < 32; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= STEP_DEN) begin
        r = r - STEP_DEN;
        q = q | 32'd1;
      end
    end
    if ((r << 1) >= STEP_DEN) q = q + 32'd1;
    return q;
  endfunction

  function automatic key_inc_tab_t build_key_inc();
    key_inc_tab_t tab;
    for (int k = 0; k < 128; k++) tab[k] = step_for_key(k);
    return tab;
  endfunction

  // first quarter of the sine wave, Q30 taylor series, scaled to 32767
  function automatic logic [15:0] quarter_sine(input int unsigned j);
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        t;
    logic signed [63:0] s;
    logic [63:0]        v;
    a = (HALF_PI_Q30 * 64'(j)) >> QTR_BITS;
    a2 = (a * a) >> 30;
    t = a;
    s = signed'(a);
    for (int k = 1; k <= 8; k++) begin
      t = ((t * a2) >> 30) / TAYLOR_DIV[k-1];
      if (k % 2 == 1) s = s - signed'(t);
      else s = s + signed'(t);
    end
    if (s < 0) return 16'd0;
    v = (64'(s) * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
    if (v > 64'(FULL_SCALE)) v = 64'(FULL_SCALE);
    return v[15:0];
  endfunction

  function automatic sine_qtr_tab_t build_sine_qtr();
    sine_qtr_tab_t tab;
    for (int j = 0; j <= QTR_SIZE; j++) tab[j] = quarter_sine(j);
    return tab;
  endfunction

  localparam key_inc_tab_t  KEY_INC  = build_key_inc();
  localparam sine_qtr_tab_t SINE_QTR = build_sine_qtr();

endpackage

[hdl/psnm_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module psnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/psnm_ctrl.sv]
// sequencer: decodes transactions, walks the voice slots, times the result
`timescale 1ns / 1ps
module psnm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_req_type,
  output logic               busy,
  output psnm_pkg::psnm_cmd_t cmd
);
  import psnm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    cmd.load    = 1'b0;
    cmd.acc_clr = 1'b0;
    cmd.issue   = 1'b0;
    cmd.slot    = step_r[SLOT_AW-1:0];
    cmd.emit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.acc_clr = 1'b1;
            step_nxt    = '0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (step_r == STEP_W'(VOICES - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_WAIT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_WAIT: begin
        // drain the voice pipeline and the scaling stages
        if (step_r == STEP_W'(WAIT_LEN - 1)) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

[hdl/psnm_dp.sv]
// datapath: voice table, per-voice phase pipeline, mix accumulator, output scaling
`timescale 1ns / 1ps
module psnm_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  psnm_pkg::psnm_cmd_t cmd,
  input  logic [3:0]          in_voice_slot,
  input  logic                in_voice_enable,
  input  logic [31:0]         in_start_sample,
  input  logic [31:0]         in_length_samples,
  input  logic [6:0]          in_key_number,
  output logic                out_valid,
  output logic signed [15:0]  out_pcm_sample
);
  import psnm_pkg::*;

  // voice table
  logic [VOICES-1:0]  slot_valid_r;
  logic [SLOT_AW-1:0] wr_slot;
  logic               slot_ok;
  logic               ram_we;
  logic [VOICE_W-1:0] ram_wdata;
  logic [VOICE_W-1:0] ram_rdata;

  logic [31:0] cnt_r;

  // pipeline stages
  logic        s1_vld_r;
  logic [31:0] rd_start, rd_len;
  logic [6:0]  rd_key;
  logic [31:0] elapsed;
  logic        sounding;
  logic        s2_snd_r;
  logic [31:0] s2_el_r;
  logic [31:0] s2_inc_r;
  logic        s3_snd_r;
  logic [31:0] s3_phase_r;
  logic [SINE_TABLE_BITS-1:0] sine_idx;
  logic [1:0]                 quad;
  logic [QTR_BITS:0]          qtr_addr;
  logic [15:0]                qtr_val;
  logic signed [15:0]         sine_val;
  logic                       s4_snd_r;
  logic signed [15:0]         s4_sine_r;

  logic signed [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0]        acc_abs;
  logic [MAG3_W-1:0]       mag3;
  logic [MAG3_W-1:0]       f1_mag3_r;
  logic                    f1_neg_r;
  logic                    f1_sat;
  logic [38:0]             f1_prod;
  logic [15:0]             f2_q_r;
  logic                    f2_sat_r;
  logic                    f2_neg_r;
  logic [15:0]             y_mag;

  logic                    out_valid_r;
  logic signed [15:0]      out_pcm_r;

  assign wr_slot   = SLOT_AW'(in_voice_slot);
  assign slot_ok   = (32'(in_voice_slot) < VOICES);
  assign ram_we    = cmd.load && slot_ok && in_voice_enable;
  assign ram_wdata = {in_start_sample, in_length_samples, in_key_number};

  psnm_ram #(
    .WIDTH (VOICE_W),
    .DEPTH (VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_slot),
    .wdata (ram_wdata),
    .raddr (cmd.slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      cnt_r        <= '0;
    end else begin
      if (cmd.load && slot_ok) slot_valid_r[wr_slot] <= in_voice_enable;
      if (cmd.emit) cnt_r <= cnt_r + 32'd1;
    end
  end

  // stage 1: window check on the slot just read
  assign rd_start = ram_rdata[VOICE_W-1 -: 32];
  assign rd_len   = ram_rdata[38:7];
  assign rd_key   = ram_rdata[6:0];
  assign elapsed  = cnt_r - rd_start;
  assign sounding = s1_vld_r && (cnt_r >= rd_start) && (elapsed <= rd_len);

  // stage 3: quarter-wave table lookup
  assign sine_idx = s3_phase_r[31 -: SINE_TABLE_BITS];
  assign quad     = sine_idx[SINE_TABLE_BITS-1 -: 2];
  assign qtr_addr = quad[0] ? ((QTR_BITS+1)'(QTR_SIZE) - {1'b0, sine_idx[QTR_BITS-1:0]})
                            : {1'b0, sine_idx[QTR_BITS-1:0]};
  assign qtr_val  = SINE_QTR[qtr_addr];
  assign sine_val = quad[1] ? -signed'(qtr_val) : signed'(qtr_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_snd_r <= 1'b0;
      s3_snd_r <= 1'b0;
      s4_snd_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue && slot_valid_r[cmd.slot];
      s2_snd_r <= sounding;
      s3_snd_r <= s2_snd_r;
      s4_snd_r <= s3_snd_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_el_r    <= elapsed;
    s2_inc_r   <= KEY_INC[rd_key];
    s3_phase_r <= 32'(s2_el_r * s2_inc_r);
    s4_sine_r  <= sine_val;
  end

  // accumulate the sounding voices
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (s4_snd_r) begin
      acc_r <= acc_r + {{(ACC_W-16){s4_sine_r[15]}}, s4_sine_r};
    end
  end

  // scale by 0.3 with truncation, clip to full scale
  assign acc_abs = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign mag3    = {acc_abs, 1'b0} + {1'b0, acc_abs};
  assign f1_sat  = (f1_mag3_r >= MAG3_W'(MAG_LIM));
  assign f1_prod = 39'(f1_mag3_r[18:0]) * 39'(RECIP_10);

  always_ff @(posedge clk) begin
    f1_mag3_r <= mag3;
    f1_neg_r  <= acc_r[ACC_W-1];
    f2_q_r    <= f1_prod[38:23];
    f2_sat_r  <= f1_sat;
    f2_neg_r  <= f1_neg_r;
  end

  assign y_mag = f2_sat_r ? FULL_SCALE : f2_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_pcm_r <= f2_neg_r ? -signed'(y_mag) : signed'(y_mag);
  end

  assign out_valid      = out_valid_r;
  assign out_pcm_sample = out_pcm_r;

endmodule

[hdl/polyphonic_sine_note_mixer_core.sv]
// top level of the polyphonic sine note mixer
// a load transaction gives no result; the next may follow at once
// a tick keeps busy high while it runs: one slot per cycle through the phase
// multiplier, then pipeline drain and the 0.3 scaling; no new tick is taken while busy
// the sample strobes on out_valid, registered from the sequencer's emit at the end of the drain; receiver cannot stall
// synchronous active-low reset clears slot valid bits, sample counter and sequencer
`timescale 1ns / 1ps
module polyphonic_sine_note_mixer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [3:0]         in_voice_slot,
  input  logic               in_voice_enable,
  input  logic [31:0]        in_start_sample,
  input  logic [31:0]        in_length_samples,
  input  logic [6:0]         in_key_number,
  output logic               out_valid,
  output logic signed [15:0] out_pcm_sample
);
  import psnm_pkg::*;

  // command bundle from the sequencer to the datapath
  psnm_cmd_t cmd;

  // sequencer: decodes load vs tick, walks slots 0..VOICES-1, then
  // counts out the pipeline drain before strobing the result
  psnm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .busy        (busy),
    .cmd         (cmd)
  );

  // datapath: voice table ram, window check, phase multiply,
  // quarter-wave sine lookup, mix accumulator and output scaling
  psnm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_voice_slot     (in_voice_slot),
    .in_voice_enable   (in_voice_enable),
    .in_start_sample   (in_start_sample),
    .in_length_samples (in_length_samples),
    .in_key_number     (in_key_number),
    .out_valid         (out_valid),
    .out_pcm_sample    (out_pcm_sample)
  );

endmodule
